// File: rtl/feedback_frame_checker_decoder_top_assert.svh
// Assertion macros shared by the frame decoder modules.
`ifndef FEEDBACK_FRAME_CHECKER_DECODER_TOP_ASSERT_SVH
`define FEEDBACK_FRAME_CHECKER_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define FFCD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("frame decoder assertion failed");

// Condition that must never be seen outside reset.
`define FFCD_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("frame decoder forbidden condition seen");

`else

`define FFCD_ASSERT(lbl, clk, rstn, prop)
`define FFCD_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// File: rtl/ffcd_pkg.sv
// Types and constants of the feedback frame checker and decoder.
`timescale 1ns / 1ps

package ffcd_pkg;

    // Frame layout
    localparam int FRAME_BYTES = 24;
    localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);
    localparam int XOR_SPAN    = 22;
    localparam int POS_HEADER  = 0;
    localparam int POS_STOP    = 1;
    localparam int POS_WORDS   = 2;
    localparam int POS_SUM     = 22;
    localparam int POS_TAIL    = 23;
    localparam int NUM_WORDS   = 10;

    // Configuration
    localparam int          CFG_IDX_W    = 1;
    localparam int          CFG_DATA_W   = 8;
    localparam logic [0:0]  CFG_HEADER   = 1'b0;
    localparam logic [0:0]  CFG_TAIL     = 1'b1;
    localparam logic [7:0]  HEADER_RESET = 8'd123;
    localparam logic [7:0]  TAIL_RESET   = 8'd125;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SIZE     = 3'd1,
        ST_HEADER   = 3'd2,
        ST_TAIL     = 3'd3,
        ST_CHECKSUM = 3'd4,
        ST_STOP     = 3'd5
    } t_status;

    // Shift line contents, cell 0 holds the newest byte
    typedef logic [FRAME_BYTES-1:0][7:0] t_chain;

    typedef struct packed {
        t_status                        status;
        logic                           stop_flag;
        logic [NUM_WORDS-1:0][15:0]     words;
    } t_result;

endpackage

// File: rtl/ffcd_cell.sv
// One byte cell of the frame shift line.
`timescale 1ns / 1ps

module ffcd_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;

    // Take the incoming byte on every shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// File: rtl/ffcd_ctrl.sv
// Byte count, running XOR and end-of-frame checks of the frame decoder.
`timescale 1ns / 1ps
`include "feedback_frame_checker_decoder_top_assert.svh"

module ffcd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    input  logic               i_frame_end,
    input  logic [7:0]         i_header,
    input  logic [7:0]         i_tail,
    input  ffcd_pkg::t_chain   i_chain,
    output logic               o_shift,
    output logic               o_res_valid,
    output ffcd_pkg::t_result  o_result
);
    import ffcd_pkg::*;

    // Frame byte p sits in cell FRAME_BYTES-2-p while the last byte is on the input
    localparam int CELL_HEADER = FRAME_BYTES - 2 - POS_HEADER;
    localparam int CELL_STOP   = FRAME_BYTES - 2 - POS_STOP;
    localparam int CELL_SUM    = FRAME_BYTES - 2 - POS_SUM;

    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_too_long, n_too_long;
    logic [7:0]         r_xor, n_xor;
    logic               w_room;
    t_status            w_status;

    assign w_room  = (r_count < COUNT_W'(FRAME_BYTES));
    assign o_shift = i_fire && w_room;

    // Advance count and XOR, restart on the last word of a frame
    always_comb begin
        n_count    = r_count;
        n_too_long = r_too_long;
        n_xor      = r_xor;
        if (i_fire) begin
            if (w_room) begin
                n_count = r_count + COUNT_W'(1);
                if (r_count < COUNT_W'(XOR_SPAN)) begin
                    n_xor = r_xor ^ i_byte;
                end
            end else begin
                n_too_long = 1'b1;
            end
            if (i_frame_end) begin
                n_count    = '0;
                n_too_long = 1'b0;
                n_xor      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_too_long <= 1'b0;
            r_xor      <= '0;
        end else begin
            r_count    <= n_count;
            r_too_long <= n_too_long;
            r_xor      <= n_xor;
        end
    end

    // Check the frame in priority order
    always_comb begin
        priority if (r_too_long || (r_count != COUNT_W'(FRAME_BYTES - 1))) begin
            w_status = ST_SIZE;
        end else if (i_chain[CELL_HEADER] != i_header) begin
            w_status = ST_HEADER;
        end else if (i_byte != i_tail) begin
            w_status = ST_TAIL;
        end else if (r_xor != i_chain[CELL_SUM]) begin
            w_status = ST_CHECKSUM;
        end else if (i_chain[CELL_STOP] > 8'd1) begin
            w_status = ST_STOP;
        end else begin
            w_status = ST_OK;
        end
    end

    // Assemble big-endian words, zero on any error
    always_comb begin
        o_result        = '0;
        o_result.status = w_status;
        if (w_status == ST_OK) begin
            o_result.stop_flag = i_chain[CELL_STOP][0];
            for (int k = 0; k < NUM_WORDS; k++) begin
                o_result.words[k] = {i_chain[FRAME_BYTES - 2 - (POS_WORDS + 2 * k)],
                                     i_chain[FRAME_BYTES - 3 - (POS_WORDS + 2 * k)]};
            end
        end
    end

    assign o_res_valid = i_fire && i_frame_end;

    `FFCD_NEVER(a_count_range, i_clk, i_rst_n, r_count > COUNT_W'(FRAME_BYTES))
    `FFCD_ASSERT(a_too_long_full, i_clk, i_rst_n,
                 r_too_long |-> (r_count == COUNT_W'(FRAME_BYTES)))
    `FFCD_ASSERT(a_restart, i_clk, i_rst_n,
                 (i_fire && i_frame_end) |=>
                     ((r_count == '0) && (r_xor == '0) && !r_too_long))

endmodule

// File: rtl/feedback_frame_checker_decoder_top.sv
// Top level of the feedback frame checker and decoder.
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_ready   i_byte_in, i_frame_end
//  result    out        o_valid / i_ready   o_status ... o_supply_voltage
//  config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One input word is taken per cycle while o_ready is high; the result of
// a frame-end word is registered in the output register. The byte shift
// line and count/XOR update finish in the accepting cycle, so words follow
// back to back. Reset is synchronous and restores header 123 and tail 125.
// A stalled result waits in the output register, a second one in the skid
// register; input is held off only while the skid register is full.
`timescale 1ns / 1ps
`include "feedback_frame_checker_decoder_top_assert.svh"

module feedback_frame_checker_decoder_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [7:0]                       i_byte_in,
    input  logic                             i_frame_end,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [2:0]                       o_status,
    output logic                             o_stop_flag,
    output logic signed [15:0]               o_linear_speed,
    output logic signed [15:0]               o_lateral_speed,
    output logic signed [15:0]               o_yaw_rate,
    output logic signed [15:0]               o_accel_x,
    output logic signed [15:0]               o_accel_y,
    output logic signed [15:0]               o_accel_z,
    output logic signed [15:0]               o_gyro_x,
    output logic signed [15:0]               o_gyro_y,
    output logic signed [15:0]               o_gyro_z,
    output logic [15:0]                      o_supply_voltage,
    input  logic                             i_cfg_we,
    input  logic [ffcd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ffcd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ffcd_pkg::*;

    logic [7:0] r_header, r_tail;
    t_chain     w_chain;
    logic       w_fire, w_shift, w_res_valid, w_out_take;
    t_result    w_result;
    logic       r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;
    t_result    r_out, n_out, r_skid, n_skid;

    assign o_ready = !r_skid_valid;
    assign w_fire  = i_valid && o_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_tail   <= TAIL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEADER: r_header <= i_cfg_data;
                CFG_TAIL:   r_tail   <= i_cfg_data;
                default:    r_header <= r_header;
            endcase
        end
    end

    // Byte shift line
    for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_cell
        if (k == 0) begin : g_head
            ffcd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_byte  (i_byte_in),
                .o_byte  (w_chain[k])
            );
        end else begin : g_body
            ffcd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_byte  (w_chain[k-1]),
                .o_byte  (w_chain[k])
            );
        end
    end

    ffcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_byte      (i_byte_in),
        .i_frame_end (i_frame_end),
        .i_header    (r_header),
        .i_tail      (r_tail),
        .i_chain     (w_chain),
        .o_shift     (w_shift),
        .o_res_valid (w_res_valid),
        .o_result    (w_result)
    );

    // Output register with skid stage
    assign w_out_take = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (w_out_take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_res_valid;
                n_out       = w_result;
            end
        end else if (w_res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_stop_flag      = r_out.stop_flag;
    assign o_linear_speed   = $signed(r_out.words[0]);
    assign o_lateral_speed  = $signed(r_out.words[1]);
    assign o_yaw_rate       = $signed(r_out.words[2]);
    assign o_accel_x        = $signed(r_out.words[3]);
    assign o_accel_y        = $signed(r_out.words[4]);
    assign o_accel_z        = $signed(r_out.words[5]);
    assign o_gyro_x         = $signed(r_out.words[6]);
    assign o_gyro_y         = $signed(r_out.words[7]);
    assign o_gyro_z         = $signed(r_out.words[8]);
    assign o_supply_voltage = r_out.words[9];

    `FFCD_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid)
    `FFCD_ASSERT(a_error_zero, i_clk, i_rst_n,
                 (r_out_valid && (r_out.status != ST_OK)) |->
                     ((r_out.words == '0) && !r_out.stop_flag))
    `FFCD_NEVER(a_no_overflow, i_clk, i_rst_n, r_skid_valid && w_res_valid)

endmodule
